>>> design/sgs_pkg.sv
// shared types, constants and reset values of the savitzky-golay smoother
`timescale 1ns / 1ps
`default_nettype none

package sgs_pkg;

    localparam int POS_W     = 32;
    localparam int INT_W     = 24;
    localparam int COEF_W    = 18;
    localparam int FRAC_W    = 16;
    localparam int NCOEF     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 4;
    localparam int COUNT_MAX = 15;

    localparam int LEFT_SPAN_DEF  = 3;
    localparam int RIGHT_SPAN_DEF = 3;
    localparam int RIGHT_SPAN_MAX = 6;
    localparam int IDX_W          = $clog2(RIGHT_SPAN_MAX + 1);

    localparam int JQ_DEPTH = 2;
    localparam int OQ_DEPTH = 4;

    localparam logic signed [COEF_W-1:0] COEF_RESET [NCOEF] = '{
        -18'sd6242, 18'sd9362, 18'sd18725, 18'sd21845, 18'sd18725, 18'sd9362, -18'sd6242
    };

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [INT_W-1:0] intensity;
        logic             last_in;
    } in_t;

    typedef struct packed {
        logic [POS_W-1:0] out_position;
        logic [INT_W-1:0] out_intensity;
        logic             last_out;
    } out_t;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [COEF_W-1:0]    data;
    } cfg_wr_t;

    // smooth: weighted sum, flush: run from start to the newest pending sample
    typedef struct packed {
        logic             smooth;
        logic             flush;
        logic [IDX_W-1:0] start;
    } job_ctl_t;

endpackage

`default_nettype wire

>>> design/sgs_fifo.sv
// small register fifo used for the job queue and the result queue
`timescale 1ns / 1ps
`default_nettype none

module sgs_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr,
    input  wire logic [W-1:0]                 wdata,
    output logic                              full,
    input  wire logic                         rd,
    output logic [W-1:0]                      rdata,
    output logic                              valid,
    output logic [$clog2(DEPTH + 1)-1:0]      count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign valid = (count_reg != '0);
    assign count = count_reg;
    assign rdata = mem_reg[rd_ptr_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> design/sgs_front.sv
// front end: takes requests, shifts the sample windows and classifies each request into a job
`timescale 1ns / 1ps
`default_nettype none

module sgs_front #(
    parameter int LEFT_SPAN  = sgs_pkg::LEFT_SPAN_DEF,
    parameter int RIGHT_SPAN = sgs_pkg::RIGHT_SPAN_DEF
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          push,
    output logic                                               full,
    input  wire sgs_pkg::in_t                                  sample,
    input  wire logic                                          jq_full,
    output logic                                               jq_push,
    output sgs_pkg::job_ctl_t                                  jq_ctl,
    output logic [LEFT_SPAN+RIGHT_SPAN:0][sgs_pkg::INT_W-1:0]  jq_win,
    output logic [RIGHT_SPAN:0][sgs_pkg::POS_W-1:0]            jq_pos
);

    localparam int TAPS  = LEFT_SPAN + RIGHT_SPAN + 1;
    localparam int PEND  = RIGHT_SPAN + 1;
    localparam int CNT_W = sgs_pkg::CNT_W;

    logic [TAPS-1:0][sgs_pkg::INT_W-1:0] win_reg, win_next;
    logic [PEND-1:0][sgs_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0]                    count_reg, count_next;
    logic [CNT_W-1:0]                    seen, k;
    logic                                accept;

    assign full   = jq_full;
    assign accept = push && !full;

    always_comb
    begin
        for (int i = 0; i < TAPS - 1; i++)
        begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[TAPS-1] = sample.intensity;
        for (int i = 0; i < PEND - 1; i++)
        begin
            pos_next[i] = pos_reg[i + 1];
        end
        pos_next[PEND-1] = sample.position;
    end

    assign jq_win = win_next;
    assign jq_pos = pos_next;

    always_comb
    begin
        seen = (count_reg == CNT_W'(sgs_pkg::COUNT_MAX)) ? count_reg : count_reg + 1'b1;
        k    = (seen < CNT_W'(PEND)) ? seen : CNT_W'(PEND);
        count_next    = count_reg;
        jq_push       = 1'b0;
        jq_ctl.smooth = 1'b0;
        jq_ctl.flush  = 1'b0;
        jq_ctl.start  = '0;
        if (sample.last_in)
        begin
            // the final request flushes every pending sample unsmoothed
            count_next   = '0;
            jq_push      = accept;
            jq_ctl.flush = 1'b1;
            jq_ctl.start = sgs_pkg::IDX_W'(CNT_W'(PEND) - k);
        end
        else
        begin
            count_next    = seen;
            jq_push       = accept && (count_reg >= CNT_W'(RIGHT_SPAN));
            jq_ctl.smooth = (count_reg >= CNT_W'(LEFT_SPAN + RIGHT_SPAN));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg <= win_next;
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

>>> design/sgs_back.sv
// back end: coefficient registers, flush sequencer and the multiply-sum-round pipeline
`timescale 1ns / 1ps
`default_nettype none

module sgs_back #(
    parameter int LEFT_SPAN  = sgs_pkg::LEFT_SPAN_DEF,
    parameter int RIGHT_SPAN = sgs_pkg::RIGHT_SPAN_DEF
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire sgs_pkg::cfg_wr_t                              cfg,
    input  wire logic                                          job_valid,
    input  wire sgs_pkg::job_ctl_t                             job_ctl,
    input  wire logic [LEFT_SPAN+RIGHT_SPAN:0][sgs_pkg::INT_W-1:0] job_win,
    input  wire logic [RIGHT_SPAN:0][sgs_pkg::POS_W-1:0]       job_pos,
    output logic                                               job_pop,
    input  wire logic [$clog2(sgs_pkg::OQ_DEPTH + 1)-1:0]      oq_count,
    output logic                                               res_wr,
    output sgs_pkg::out_t                                      res
);

    localparam int TAPS   = LEFT_SPAN + RIGHT_SPAN + 1;
    localparam int PEND   = RIGHT_SPAN + 1;
    localparam int INT_W  = sgs_pkg::INT_W;
    localparam int POS_W  = sgs_pkg::POS_W;
    localparam int COEF_W = sgs_pkg::COEF_W;
    localparam int FRAC_W = sgs_pkg::FRAC_W;
    localparam int NCOEF  = sgs_pkg::NCOEF;
    localparam int IDX_W  = sgs_pkg::IDX_W;
    localparam int PROD_W = INT_W + 1 + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(TAPS + 1);
    localparam int SH_W   = ACC_W - FRAC_W;
    localparam int PI_W   = $clog2(PEND);
    localparam int WI_W   = $clog2(TAPS);
    localparam int OQ_CW  = $clog2(sgs_pkg::OQ_DEPTH + 1);
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_W - 1);
    localparam logic [sgs_pkg::CFG_IDX_W-1:0] CFG_LIM = sgs_pkg::CFG_IDX_W'(NCOEF);

    logic signed [COEF_W-1:0] coef_reg [NCOEF];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= sgs_pkg::COEF_RESET;
        end
        else if (cfg.we && (cfg.index < CFG_LIM))
        begin
            coef_reg[cfg.index] <= cfg.data;
        end
    end

    // flush sequencer
    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] cur_idx;
    logic [WI_W-1:0]  win_idx;
    logic             last_op, done_op, issue;
    logic [OQ_CW:0]   occupancy;

    logic s1_valid_reg, s2_valid_reg;

    assign occupancy = (OQ_CW + 1)'(oq_count) + (OQ_CW + 1)'(s1_valid_reg)
                     + (OQ_CW + 1)'(s2_valid_reg);
    assign issue   = job_valid && (occupancy < (OQ_CW + 1)'(sgs_pkg::OQ_DEPTH));
    assign cur_idx = busy_reg ? idx_reg : job_ctl.start;
    assign win_idx = WI_W'(TAPS - PEND) + WI_W'(cur_idx);
    assign last_op = job_ctl.flush && (cur_idx == IDX_W'(PEND - 1));
    assign done_op = !job_ctl.flush || last_op;
    assign job_pop = issue && done_op;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (issue)
        begin
            busy_next = !done_op;
            idx_next  = cur_idx + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // stage 1: one multiplier per tap, taps past the register set weigh nothing
    logic signed [PROD_W-1:0] prod_next [TAPS];

    for (genvar t = 0; t < TAPS; t++)
    begin : g_tap
        if (t < NCOEF)
        begin : g_mul
            logic signed [INT_W:0]    w_ext;
            logic signed [COEF_W-1:0] c_ext;
            assign w_ext        = {1'b0, job_win[t]};
            assign c_ext        = coef_reg[t];
            assign prod_next[t] = w_ext * c_ext;
        end
        else
        begin : g_zero
            assign prod_next[t] = '0;
        end
    end

    logic signed [PROD_W-1:0] s1_prod_reg [TAPS];
    logic                     s1_smooth_reg, s1_last_reg;
    logic [INT_W-1:0]         s1_pass_reg;
    logic [POS_W-1:0]         s1_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_prod_reg   <= prod_next;
            s1_smooth_reg <= job_ctl.smooth;
            s1_last_reg   <= last_op;
            s1_pass_reg   <= job_win[win_idx];
            s1_pos_reg    <= job_pos[cur_idx[PI_W-1:0]];
        end
    end

    // stage 2: sum of products
    logic signed [ACC_W-1:0] acc_next, s2_acc_reg;
    logic                    s2_smooth_reg, s2_last_reg;
    logic [INT_W-1:0]        s2_pass_reg;
    logic [POS_W-1:0]        s2_pos_reg;

    always_comb
    begin
        acc_next = '0;
        for (int t = 0; t < TAPS; t++)
        begin
            acc_next = acc_next + ACC_W'(s1_prod_reg[t]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_acc_reg    <= acc_next;
            s2_smooth_reg <= s1_smooth_reg;
            s2_last_reg   <= s1_last_reg;
            s2_pass_reg   <= s1_pass_reg;
            s2_pos_reg    <= s1_pos_reg;
        end
    end

    // round half up, clamp at zero, saturate at the intensity maximum
    logic signed [ACC_W-1:0] rnd;
    logic [SH_W-1:0]         shifted;
    logic [INT_W-1:0]        smooth_val;

    always_comb
    begin
        rnd     = s2_acc_reg + HALF;
        shifted = rnd[ACC_W-1:FRAC_W];
        if (s2_acc_reg[ACC_W-1])
        begin
            smooth_val = '0;
        end
        else if (|shifted[SH_W-1:INT_W])
        begin
            smooth_val = '1;
        end
        else
        begin
            smooth_val = shifted[INT_W-1:0];
        end
    end

    assign res_wr            = s2_valid_reg;
    assign res.out_position  = s2_pos_reg;
    assign res.out_intensity = s2_smooth_reg ? smooth_val : s2_pass_reg;
    assign res.last_out      = s2_last_reg;

endmodule

`default_nettype wire

>>> design/savitzky_golay_smoother.sv
// top level of the streaming savitzky-golay smoother
//
//  port group                        dir   handshake           payload
//  push / full / sample              in    push & !full        sgs_pkg::in_t
//  pop / empty / result              out   pop & !empty        sgs_pkg::out_t
//  cfg_we / cfg_index / cfg_data     in    cfg_we              coef_0..coef_6, q1.16
//
// one request per cycle is taken while full is low; a request that ends a spectrum
// holds the back end while the flush sequencer issues its flushed samples, up to RIGHT_SPAN+1
// a result passes the job queue, stage 1, stage 2 and the result queue to the result port
// full rises when the two-entry job queue holds two jobs; the back end holds off issue
// while results in its two pipeline stages and the four-entry result queue add up to four
// reset clears counts and pointers and loads COEF_RESET at once; there is no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module savitzky_golay_smoother #(
    parameter int LEFT_SPAN  = sgs_pkg::LEFT_SPAN_DEF,
    parameter int RIGHT_SPAN = sgs_pkg::RIGHT_SPAN_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire sgs_pkg::in_t                      sample,
    input  wire logic                              pop,
    output logic                                   empty,
    output sgs_pkg::out_t                          result,
    input  wire logic                              cfg_we,
    input  wire logic [sgs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sgs_pkg::COEF_W-1:0]        cfg_data
);

    localparam int TAPS  = LEFT_SPAN + RIGHT_SPAN + 1;
    localparam int PEND  = RIGHT_SPAN + 1;
    localparam int JOB_W = $bits(sgs_pkg::job_ctl_t) + TAPS * sgs_pkg::INT_W
                         + PEND * sgs_pkg::POS_W;
    localparam int OQ_CW = $clog2(sgs_pkg::OQ_DEPTH + 1);

    sgs_pkg::cfg_wr_t                    cfg;
    sgs_pkg::job_ctl_t                   f_ctl, b_ctl;
    logic [TAPS-1:0][sgs_pkg::INT_W-1:0] f_win, b_win;
    logic [PEND-1:0][sgs_pkg::POS_W-1:0] f_pos, b_pos;
    logic [JOB_W-1:0]                    jq_wdata, jq_rdata;
    logic                                jq_push, jq_full, jq_pop, jq_valid;
    logic                                res_wr, oq_valid;
    sgs_pkg::out_t                       res;
    logic [OQ_CW-1:0]                    oq_count;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    sgs_front #(
        .LEFT_SPAN  (LEFT_SPAN),
        .RIGHT_SPAN (RIGHT_SPAN)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .sample  (sample),
        .jq_full (jq_full),
        .jq_push (jq_push),
        .jq_ctl  (f_ctl),
        .jq_win  (f_win),
        .jq_pos  (f_pos)
    );

    assign jq_wdata = {f_ctl, f_win, f_pos};
    assign {b_ctl, b_win, b_pos} = jq_rdata;

    sgs_fifo #(
        .W     (JOB_W),
        .DEPTH (sgs_pkg::JQ_DEPTH)
    ) u_jobq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (jq_push),
        .wdata (jq_wdata),
        .full  (jq_full),
        .rd    (jq_pop),
        .rdata (jq_rdata),
        .valid (jq_valid),
        .count ()
    );

    sgs_back #(
        .LEFT_SPAN  (LEFT_SPAN),
        .RIGHT_SPAN (RIGHT_SPAN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (jq_valid),
        .job_ctl   (b_ctl),
        .job_win   (b_win),
        .job_pos   (b_pos),
        .job_pop   (jq_pop),
        .oq_count  (oq_count),
        .res_wr    (res_wr),
        .res       (res)
    );

    sgs_fifo #(
        .W     ($bits(sgs_pkg::out_t)),
        .DEPTH (sgs_pkg::OQ_DEPTH)
    ) u_resq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_wr),
        .wdata (res),
        .full  (),
        .rd    (pop),
        .rdata (result),
        .valid (oq_valid),
        .count (oq_count)
    );

    assign empty = !oq_valid;

    // the issue credit must keep the result queue from overflowing
    a_resq_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_wr |-> (oq_count != OQ_CW'(sgs_pkg::OQ_DEPTH)))
        else $error("result queue written while full");

    // an accepted end of spectrum always turns into a flush job
    a_last_job: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && sample.last_in) |-> (jq_push && f_ctl.flush))
        else $error("final request produced no flush job");

    // the back end only retires a job that is there
    a_job_pop: assert property (@(posedge clk) disable iff (!rst_n)
        jq_pop |-> jq_valid)
        else $error("job queue read while empty");

endmodule

`default_nettype wire
